/* hdl/wbps_pkg.sv */
// Shared types and constants of the wildcard byte pattern scan unit.
package wbps_pkg;

	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 6;
	localparam int REG_W     = 64;
	localparam int PAT_REGS  = 4;
	localparam int PAT_BYTES = 32;
	localparam int CFG_IDX_W = 3;

	localparam logic [BYTE_W-1:0] WILDCARD_BYTE = 8'hCC;

	localparam logic [CFG_IDX_W-1:0] REG_PAT_0_7   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_8_15  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_16_23 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_24_31 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAT_LEN   = 3'd4;

	typedef struct packed {
		logic emit;
		logic found;
	} scan_res_t;

endpackage

/* hdl/wbps_cfg.sv */
// Configuration registers and the pattern aligned to the window.
module wbps_cfg import wbps_pkg::*; #(
	parameter int MAX_PATTERN = 32
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_wr,
	input  logic [CFG_IDX_W-1:0]                    cfg_index,
	input  logic [REG_W-1:0]                        cfg_data,
	output logic [MAX_PATTERN-1:0][BYTE_W-1:0]      apat,
	output logic [MAX_PATTERN-1:0]                  care,
	output logic [LEN_W-1:0]                        len
);

	logic [PAT_REGS-1:0][REG_W-1:0]     pat_q;
	logic [LEN_W-1:0]                   len_raw_q;
	logic [PAT_BYTES-1:0][BYTE_W-1:0]   pat_bytes;
	logic [LEN_W-1:0]                   len_c;
	logic [MAX_PATTERN-1:0][BYTE_W-1:0] apat_d;
	logic [MAX_PATTERN-1:0]             care_d;
	logic [MAX_PATTERN-1:0][BYTE_W-1:0] apat_q;
	logic [MAX_PATTERN-1:0]             care_q;
	logic [LEN_W-1:0]                   len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q     <= '0;
			len_raw_q <= LEN_W'(1);
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_PAT_0_7:   pat_q[0]  <= cfg_data;
				REG_PAT_8_15:  pat_q[1]  <= cfg_data;
				REG_PAT_16_23: pat_q[2]  <= cfg_data;
				REG_PAT_24_31: pat_q[3]  <= cfg_data;
				REG_PAT_LEN:   len_raw_q <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign pat_bytes = pat_q;

	always_comb begin
		logic [LEN_W-1:0] k;
		k = '0;
		if (len_raw_q == '0)
			len_c = LEN_W'(1);
		else if (len_raw_q > LEN_W'(MAX_PATTERN))
			len_c = LEN_W'(MAX_PATTERN);
		else
			len_c = len_raw_q;
		for (int j = 0; j < MAX_PATTERN; j++) begin
			k = len_c - LEN_W'(1) - LEN_W'(j);
			if (LEN_W'(j) < len_c) begin
				apat_d[j] = pat_bytes[k[4:0]];
				care_d[j] = (pat_bytes[k[4:0]] != WILDCARD_BYTE);
			end else begin
				apat_d[j] = '0;
				care_d[j] = 1'b0;
			end
		end
	end

	// Aligned copy is registered; writes must come only while idle, which is not enforced.
	always_ff @(posedge clk) begin
		apat_q <= apat_d;
		care_q <= care_d;
		len_q  <= len_c;
	end

	assign apat = apat_q;
	assign care = care_q;
	assign len  = len_q;

endmodule

/* hdl/wbps_scan.sv */
// Sliding window, byte counter and parallel masked compare.
module wbps_scan import wbps_pkg::*; #(
	parameter int MAX_PATTERN  = 32,
	parameter int OFFSET_WIDTH = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               step,
	input  logic [BYTE_W-1:0]                  data_byte,
	input  logic                               last_byte,
	input  logic [MAX_PATTERN-1:0][BYTE_W-1:0] apat,
	input  logic [MAX_PATTERN-1:0]             care,
	input  logic [LEN_W-1:0]                   len,
	output scan_res_t                          res,
	output logic [OFFSET_WIDTH-1:0]            offset
);

	logic [MAX_PATTERN-1:0][BYTE_W-1:0] window_q;
	logic [MAX_PATTERN-1:0][BYTE_W-1:0] win_next;
	logic [OFFSET_WIDTH-1:0]            count_q;
	logic [OFFSET_WIDTH-1:0]            cnt_next;
	logic                               seen_q;
	logic [MAX_PATTERN-1:0]             ok;
	logic                               hit;

	always_comb begin
		win_next[0] = data_byte;
		for (int i = 1; i < MAX_PATTERN; i++)
			win_next[i] = window_q[i-1];
		for (int j = 0; j < MAX_PATTERN; j++)
			ok[j] = !care[j] || (win_next[j] == apat[j]);
	end

	assign cnt_next = (count_q == '1) ? count_q : count_q + OFFSET_WIDTH'(1);
	assign hit      = (&ok) && (cnt_next >= OFFSET_WIDTH'(len)) && !seen_q;
	assign offset   = hit ? cnt_next - OFFSET_WIDTH'(len) : '0;

	always_comb begin
		res.found = hit;
		res.emit  = hit || (last_byte && !seen_q);
	end

	// Stale window bytes never decide a match because the count gates every match.
	always_ff @(posedge clk) begin
		if (step)
			window_q <= win_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			seen_q  <= 1'b0;
		end else if (step) begin
			if (last_byte) begin
				count_q <= '0;
				seen_q  <= 1'b0;
			end else begin
				count_q <= cnt_next;
				seen_q  <= seen_q || hit;
			end
		end
	end

endmodule

/* hdl/wildcard_byte_pattern_scan_unit.sv */
// Top level of the wildcard byte pattern scan unit.
//
// Channel  Signals                                        Direction
// byte     byte_valid, byte_stall, data_byte, last_byte   beats in
// result   result_valid, result_stall, found, match_offset beats out
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data      writes in
//
// One byte beat is taken every cycle unless stalled; results pass the input and result registers.
// The rate is set by the single compare stage between the input and result registers.
// Reset clears the pattern to zeros with length one and empties both stages.
// A stalled result holds the compare stage, which then stalls the byte channel.
module wildcard_byte_pattern_scan_unit import wbps_pkg::*; #(
	parameter int MAX_PATTERN  = 32,
	parameter int OFFSET_WIDTH = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    byte_valid,
	output logic                    byte_stall,
	input  logic [BYTE_W-1:0]       data_byte,
	input  logic                    last_byte,
	output logic                    result_valid,
	input  logic                    result_stall,
	output logic                    found,
	output logic [OFFSET_WIDTH-1:0] match_offset,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [REG_W-1:0]        cfg_data
);

	logic [MAX_PATTERN-1:0][BYTE_W-1:0] apat;
	logic [MAX_PATTERN-1:0]             care;
	logic [LEN_W-1:0]                   len;
	logic                               valid_s1;
	logic [BYTE_W-1:0]                  byte_s1;
	logic                               last_s1;
	logic                               valid_s2;
	logic                               found_s2;
	logic [OFFSET_WIDTH-1:0]            offset_s2;
	logic                               out_free;
	logic                               advance;
	logic                               accept;
	scan_res_t                          res;
	logic [OFFSET_WIDTH-1:0]            offset;

	assign cfg_ready  = 1'b1;
	assign out_free   = !valid_s2 || !result_stall;
	assign advance    = valid_s1 && out_free;
	assign byte_stall = valid_s1 && !out_free;
	assign accept     = byte_valid && !byte_stall;

	wbps_cfg #(
		.MAX_PATTERN(MAX_PATTERN)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.apat      (apat),
		.care      (care),
		.len       (len)
	);

	wbps_scan #(
		.MAX_PATTERN (MAX_PATTERN),
		.OFFSET_WIDTH(OFFSET_WIDTH)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.apat      (apat),
		.care      (care),
		.len       (len),
		.res       (res),
		.offset    (offset)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (out_free)
				valid_s2 <= advance && res.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
		if (advance && res.emit) begin
			found_s2  <= res.found;
			offset_s2 <= offset;
		end
	end

	assign result_valid = valid_s2;
	assign found        = found_s2;
	assign match_offset = offset_s2;

endmodule

/* test/testbench.sv */
`timescale 1ns / 100ps
// Testbench for the wildcard byte pattern scan unit, checking every result beat against a prediction.
module testbench;
	import wbps_pkg::*;

	localparam int OFFSET_W   = 32;
	localparam int STALL_LIMIT = 4000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct packed {
		logic                found;
		logic [OFFSET_W-1:0] offset;
	} scan_outcome_t;

	class scan_scoreboard;
		logic [REG_W-1:0]    pat_reg[PAT_REGS];
		logic [LEN_W-1:0]    pat_len;
		logic [BYTE_W-1:0]   win[PAT_BYTES];
		logic [OFFSET_W-1:0] seen_bytes;
		bit                  matched;
		scan_outcome_t       outcome_q[$];
		int                  fail_count;
		int                  checked;
		int                  found_count;

		function new();
			foreach (pat_reg[r]) pat_reg[r] = '0;
			pat_len = 1;
			clear_scan();
		endfunction

		function void clear_scan();
			foreach (win[i]) win[i] = '0;
			seen_bytes = '0;
			matched = 0;
		endfunction

		function int eff_len();
			if (pat_len == 0) return 1;
			if (pat_len > PAT_BYTES) return PAT_BYTES;
			return pat_len;
		endfunction

		function logic [BYTE_W-1:0] pat_byte(int k);
			return pat_reg[k >> 3][(k & 7) * 8 +: 8];
		endfunction

		function int pending();
			return outcome_q.size();
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
			case (idx)
				REG_PAT_0_7, REG_PAT_8_15, REG_PAT_16_23, REG_PAT_24_31: begin
					pat_reg[idx] = val;
				end
				REG_PAT_LEN: begin
					pat_len = val[LEN_W-1:0];
				end
				default: begin
				end
			endcase
		endfunction

		function void note_byte(logic [BYTE_W-1:0] d, logic last);
			int n;
			bit hit;
			logic [BYTE_W-1:0] p;
			scan_outcome_t o;
			n = eff_len();
			for (int i = PAT_BYTES - 1; i > 0; i--) win[i] = win[i-1];
			win[0] = d;
			if (seen_bytes != '1) seen_bytes++;
			if (!matched && seen_bytes >= n) begin
				hit = 1;
				for (int k = 0; k < n; k++) begin
					p = pat_byte(k);
					if (p != WILDCARD_BYTE && p != win[n-1-k]) hit = 0;
				end
				if (hit) begin
					matched = 1;
					o.found = 1;
					o.offset = seen_bytes - n;
					outcome_q.push_back(o);
				end
			end
			if (last) begin
				if (!matched) begin
					o.found = 0;
					o.offset = '0;
					outcome_q.push_back(o);
				end
				clear_scan();
			end
		endfunction

		function void check_result(logic f, logic [OFFSET_W-1:0] off);
			scan_outcome_t e;
			if (outcome_q.size() == 0) begin
				$display("%0t: unexpected result beat, found=%0b offset=%0d", $time, f, off);
				fail_count++;
				return;
			end
			e = outcome_q.pop_front();
			checked++;
			if (e.found) found_count++;
			if (f !== e.found) begin
				$display("%0t: found mismatch, expected %0b, actual %0b", $time, e.found, f);
				fail_count++;
			end
			if (off !== e.offset) begin
				$display("%0t: match_offset mismatch, expected %0d, actual %0d",
					$time, e.offset, off);
				fail_count++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  byte_valid;
	logic                  byte_stall;
	logic [BYTE_W-1:0]     data_byte;
	logic                  last_byte;
	logic                  result_valid;
	logic                  result_stall;
	logic                  found;
	logic [OFFSET_W-1:0]   match_offset;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [REG_W-1:0]      cfg_data;

	scan_scoreboard sb;
	logic [BYTE_W-1:0] image_q[$];
	int send_idle_pct;
	int recv_stall_pct;
	int bytes_sent;
	int images;
	int cfg_writes;
	int idle_cycles;

	wildcard_byte_pattern_scan_unit #(
		.MAX_PATTERN(PAT_BYTES),
		.OFFSET_WIDTH(OFFSET_W)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_stall(byte_stall),
		.data_byte(data_byte),
		.last_byte(last_byte),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.found(found),
		.match_offset(match_offset),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	always @(negedge clk) begin
		result_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	initial begin
		logic hit;
		logic f;
		logic [OFFSET_W-1:0] off;
		forever begin
			@(posedge clk);
			hit = arst_n && result_valid && !result_stall;
			f = found;
			off = match_offset;
			@(negedge clk);
			if (hit) sb.check_result(f, off);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (result_valid && !result_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("Watchdog: no beat for %0d cycles at %0t", STALL_LIMIT, $time);
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_byte(input logic [BYTE_W-1:0] d, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			byte_valid <= 1'b0;
		end
		@(negedge clk);
		byte_valid <= 1'b1;
		data_byte <= d;
		last_byte <= last;
		forever begin
			@(posedge clk);
			if (!byte_stall) break;
		end
		sb.note_byte(d, last);
		bytes_sent++;
	endtask

	task automatic send_image(input bit close);
		for (int i = 0; i < image_q.size(); i++) begin
			send_byte(image_q[i], close && (i == image_q.size() - 1));
		end
		if (close) images++;
	endtask

	task automatic wait_idle();
		@(negedge clk);
		byte_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		forever begin
			@(posedge clk);
			if (cfg_ready) break;
		end
		sb.write_reg(idx, val);
		cfg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic load_pattern(input int force_len);
		logic [REG_W-1:0] val;
		int len;
		for (int r = 0; r < PAT_REGS; r++) begin
			for (int k = 0; k < 8; k++) begin
				val[k*8 +: 8] = ($urandom_range(99) < 30) ? WILDCARD_BYTE : 8'($urandom_range(255));
			end
			if (force_len >= 0 || $urandom_range(9) < 7) write_cfg(CFG_IDX_W'(r), val);
		end
		if (force_len >= 0) begin
			len = force_len;
		end else begin
			case ($urandom_range(9))
				0: len = 0;
				1: len = PAT_BYTES;
				2: len = $urandom_range(PAT_BYTES + 1, (1 << LEN_W) - 1);
				3, 4: len = $urandom_range(9, PAT_BYTES - 1);
				default: len = $urandom_range(1, 8);
			endcase
		end
		write_cfg(REG_PAT_LEN, REG_W'(len));
		if ($urandom_range(4) == 0) begin
			write_cfg(CFG_IDX_W'($urandom_range(REG_PAT_LEN + 1, (1 << CFG_IDX_W) - 1)),
				{$urandom, $urandom});
		end
	endtask

	task automatic random_image();
		int n;
		int kind;
		int k;
		logic [BYTE_W-1:0] p;
		n = sb.eff_len();
		kind = $urandom_range(9);
		image_q.delete();
		if (kind <= 7) begin
			repeat ($urandom_range(6)) image_q.push_back(8'($urandom_range(255)));
			k = image_q.size();
			for (int i = 0; i < n; i++) begin
				p = sb.pat_byte(i);
				image_q.push_back(p == WILDCARD_BYTE ? 8'($urandom_range(255)) : p);
			end
			if (kind == 7) begin
				k = k + $urandom_range(n - 1);
				image_q[k] = ~image_q[k];
			end
			repeat ($urandom_range(4)) image_q.push_back(8'($urandom_range(255)));
		end else if (kind == 8 && n > 1) begin
			repeat ($urandom_range(1, n - 1)) image_q.push_back(8'($urandom_range(255)));
		end else begin
			repeat ($urandom_range(1, 12)) image_q.push_back(8'($urandom_range(255)));
		end
		send_image(1'b1);
	endtask

	initial begin
		int target;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		data_byte = '0;
		last_byte = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		sb = new();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset pattern is a single zero byte.
		image_q = '{8'hFF, 8'h00};
		send_image(1'b1);
		image_q = '{8'h00, 8'h7F};
		send_image(1'b1);
		wait_idle();
		write_cfg(REG_PAT_0_7, 64'h0000_0000_0055_CCAA);
		write_cfg(REG_PAT_8_15, 64'hFFFF_FFFF_FFFF_FFFF);
		write_cfg(REG_PAT_16_23, 64'hCCCC_CCCC_CCCC_CCCC);
		write_cfg(REG_PAT_24_31, 64'h0000_0000_0000_0000);
		write_cfg(REG_PAT_LEN, 64'd3);
		image_q = '{8'h11, 8'hAA, 8'h7E, 8'h55, 8'h22};
		send_image(1'b1);
		image_q = '{8'hAA, 8'h00};
		send_image(1'b1);
		image_q = '{8'hAA, 8'hCC, 8'hCC, 8'h80};
		send_image(1'b1);
		wait_idle();
		write_cfg(REG_PAT_LEN, 64'd0);
		write_cfg(CFG_IDX_W'(REG_PAT_LEN + 1), 64'hFFFF_FFFF_FFFF_FFFF);
		image_q = '{8'h00, 8'hAA};
		send_image(1'b1);
		wait_idle();
		write_cfg(REG_PAT_LEN, 64'd2);
		image_q = '{8'h01, 8'h02};
		send_image(1'b0);
		wait_idle();
		write_cfg(REG_PAT_LEN, 64'd1);
		image_q = '{8'hAA};
		send_image(1'b1);

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
				default: begin send_idle_pct = 11; recv_stall_pct = 11; end
			endcase
			wait_idle();
			case (ph)
				1: load_pattern(PAT_BYTES);
				2: load_pattern((1 << LEN_W) - 1);
				default: load_pattern(-1);
			endcase
			target = bytes_sent + 100;
			while (bytes_sent < target) begin
				if ($urandom_range(2) == 0) begin
					wait_idle();
					load_pattern(-1);
				end
				random_image();
			end
		end

		wait_idle();
		$display("Scanned %0d bytes in %0d images under four pacing modes, %0d register writes.",
			bytes_sent, images, cfg_writes);
		$display("%0d result beats checked, %0d of them matches.", sb.checked, sb.found_count);
		if (sb.fail_count == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
